@@ rtl/core/fhs_pkg.sv @@
// shared types and constants for the fire heat stencil
`timescale 1ns / 1ps
`default_nettype none

package fhs_pkg;

    localparam int HEAT_W = 4;
    localparam int CFG_W  = 8;

    // row counter saturates once two full rows are buffered
    localparam logic [1:0] ROW_SAT = 2'd2;

    // input transaction payload
    typedef struct packed {
        logic [HEAT_W-1:0] heat_in;
        logic              end_of_frame;
    } in_item_t;

    // result transaction payload
    typedef struct packed {
        logic [HEAT_W-1:0] heat_out;
        logic              frame_done;
    } out_item_t;

    // controls from the sequencer to the window cells
    typedef struct packed {
        logic wr_en;
        logic advance;
        logic left_load;
        logic left_clear;
    } win_ctl_t;

    // position of the current pixel within the frame
    typedef struct packed {
        logic first_col;
        logic last_col;
        logic produce;
    } pos_t;

endpackage

`default_nettype wire

@@ rtl/core/fhs_window.sv @@
// line buffer and the three-cell stencil window above the current pixel
`timescale 1ns / 1ps
`default_nettype none

module fhs_window
    import fhs_pkg::*;
#(
    parameter int WIDTH_MAX = 128
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire win_ctl_t                     ctl,
    input  wire logic [$clog2(WIDTH_MAX)-1:0] wr_addr,
    input  wire logic [HEAT_W-1:0]            wr_data,
    input  wire logic [$clog2(WIDTH_MAX)-1:0] rd_addr_a,
    input  wire logic [$clog2(WIDTH_MAX)-1:0] rd_addr_b,
    output logic      [HEAT_W-1:0]            left_tap,
    output logic      [HEAT_W-1:0]            above_tap,
    output logic      [HEAT_W-1:0]            right_tap
);

    // previous row, partly overwritten by the current row
    logic [HEAT_W-1:0] row_store_reg [WIDTH_MAX];

    // window cells: left, above, right of the row above
    logic [HEAT_W-1:0] tap_reg [3];

    // line buffer write and the window cells
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            row_store_reg[wr_addr] <= wr_data;
        end
        // above and right cells, write-first on a match; the above cell takes the right cell on advance
        if (ctl.advance) begin
            tap_reg[1] <= tap_reg[2];
        end else if (ctl.wr_en && (wr_addr == rd_addr_a)) begin
            tap_reg[1] <= wr_data;
        end else begin
            tap_reg[1] <= row_store_reg[rd_addr_a];
        end
        if (ctl.wr_en && (wr_addr == rd_addr_b)) begin
            tap_reg[2] <= wr_data;
        end else begin
            tap_reg[2] <= row_store_reg[rd_addr_b];
        end
        // left cell takes the above cell on each transaction, cleared at the end of a row or frame
        if (!aresetn) begin
            tap_reg[0] <= '0;
        end else if (ctl.left_clear) begin
            tap_reg[0] <= '0;
        end else if (ctl.left_load) begin
            tap_reg[0] <= tap_reg[1];
        end
    end

    assign left_tap  = tap_reg[0];
    assign above_tap = tap_reg[1];
    assign right_tap = tap_reg[2];

endmodule

`default_nettype wire

@@ rtl/core/fhs_ctrl.sv @@
// column and row sequencer, width register and line buffer addressing
`timescale 1ns / 1ps
`default_nettype none

module fhs_ctrl
    import fhs_pkg::*;
#(
    parameter int WIDTH_MAX = 128
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [CFG_W-1:0]             cfg_wr_data,
    input  wire logic                         accept,
    input  wire logic                         end_of_frame,
    output logic      [$clog2(WIDTH_MAX)-1:0] wr_addr,
    output logic      [$clog2(WIDTH_MAX)-1:0] rd_addr_a,
    output logic      [$clog2(WIDTH_MAX)-1:0] rd_addr_b,
    output win_ctl_t                          win_ctl,
    output pos_t                              pos
);

    localparam int AW = $clog2(WIDTH_MAX);
    localparam int CW = $clog2(WIDTH_MAX + 1);
    localparam int WW = (CW > CFG_W) ? CW : CFG_W;
    localparam int WIDTH_MIN = 3;
    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(96);

    logic [CFG_W-1:0] width_reg, width_next;
    logic [AW-1:0]    col_reg, col_next;
    logic [1:0]       row_reg, row_next;

    logic [WW-1:0] last_idx_cur, last_idx_nx;
    logic          last_col;
    logic [AW-1:0] x_cur;
    logic [AW-1:0] a0_nx;

    // width register clamped into the supported range
    function automatic logic [WW-1:0] eff_width(input logic [CFG_W-1:0] raw);
        logic [WW-1:0] ext;
        ext = WW'(raw);
        if (ext < WW'(WIDTH_MIN)) begin
            ext = WW'(WIDTH_MIN);
        end else if (ext > WW'(WIDTH_MAX)) begin
            ext = WW'(WIDTH_MAX);
        end
        return ext;
    endfunction

    // current column, pinned to the last column of the row
    always_comb begin
        last_idx_cur = eff_width(width_reg) - WW'(1);
        last_col     = (WW'(col_reg) >= last_idx_cur);
        x_cur        = last_col ? AW'(last_idx_cur) : col_reg;
    end

    // counter and register next values
    always_comb begin
        width_next = cfg_wr_en ? cfg_wr_data : width_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        if (accept) begin
            if (last_col || end_of_frame) begin
                col_next = '0;
            end else begin
                col_next = x_cur + AW'(1);
            end
            if (end_of_frame) begin
                row_next = '0;
            end else if (last_col && (row_reg != ROW_SAT)) begin
                row_next = row_reg + 2'd1;
            end
        end
    end

    // prefetch addresses for the position after this edge
    always_comb begin
        last_idx_nx = eff_width(width_next) - WW'(1);
        a0_nx       = (WW'(col_next) >= last_idx_nx) ? AW'(last_idx_nx) : col_next;
        rd_addr_a   = a0_nx;
        rd_addr_b   = (a0_nx == AW'(WIDTH_MAX - 1)) ? a0_nx : a0_nx + AW'(1);
    end

    // window and write controls
    always_comb begin
        wr_addr            = x_cur;
        win_ctl.wr_en      = accept;
        win_ctl.advance    = accept && !last_col && !end_of_frame && !cfg_wr_en;
        win_ctl.left_load  = accept;
        win_ctl.left_clear = accept && (last_col || end_of_frame);
        pos.first_col      = (x_cur == '0);
        pos.last_col       = last_col;
        pos.produce        = (row_reg == ROW_SAT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_RESET;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            width_reg <= width_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/fire_heat_stencil.sv @@
// top level of the fire heat stencil: four-neighbor heat average over a line buffer
//
//   channel  ports              direction  payload
//   input    s_valid/s_ready    in         s_data  (heat_in, end_of_frame)
//   result   m_valid/m_ready    out        m_data  (heat_out, frame_done)
//   config   cfg_wr_en          in         cfg_wr_data (width_in_use)
//
// One pixel is taken per clock unless the output stalls; a result leaves the next cycle.
// The line buffer is prefetched one position ahead into the window cells, so
// its registered read port adds no delay; the output register alone lies in the path.
// Reset is synchronous, active low; the line buffer contents are not cleared.
// A full output register that is not drained stalls the input side.
`timescale 1ns / 1ps
`default_nettype none

module fire_heat_stencil
    import fhs_pkg::*;
#(
    parameter int WIDTH_MAX = 128
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_item_t         s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_item_t             m_data
);

    localparam int AW = $clog2(WIDTH_MAX);

    logic          accept;
    win_ctl_t      win_ctl;
    pos_t          pos;
    logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
    logic [HEAT_W-1:0] left_tap, above_tap, right_tap;
    logic [HEAT_W-1:0] left_v, right_v;
    logic [HEAT_W+1:0] sum;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg;

    // input handshake
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    fhs_ctrl #(
        .WIDTH_MAX (WIDTH_MAX)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .accept       (accept),
        .end_of_frame (s_data.end_of_frame),
        .wr_addr      (wr_addr),
        .rd_addr_a    (rd_addr_a),
        .rd_addr_b    (rd_addr_b),
        .win_ctl      (win_ctl),
        .pos          (pos)
    );

    fhs_window #(
        .WIDTH_MAX (WIDTH_MAX)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (win_ctl),
        .wr_addr   (wr_addr),
        .wr_data   (s_data.heat_in),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .left_tap  (left_tap),
        .above_tap (above_tap),
        .right_tap (right_tap)
    );

    // stencil sum, horizontal neighbors outside the frame read as zero
    always_comb begin
        left_v  = pos.first_col ? '0 : left_tap;
        right_v = pos.last_col  ? '0 : right_tap;
        sum     = (HEAT_W+2)'(left_v) + (HEAT_W+2)'(above_tap)
                + (HEAT_W+2)'(right_v) + (HEAT_W+2)'(s_data.heat_in);
    end

    // output register valid
    always_comb begin
        if (accept && pos.produce) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (accept && pos.produce) begin
            m_data_reg.heat_out   <= sum[HEAT_W+1:2];
            m_data_reg.frame_done <= s_data.end_of_frame;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a transaction past the second row always leaves a result
    a_result_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && pos.produce) |=> m_valid_reg)
        else $error("result missing after a producing transaction");

    // end of frame restarts the row count
    a_eof_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.end_of_frame) |=> (!pos.produce && pos.first_col))
        else $error("counters not restarted after end of frame");

    // a row wraps to the first column
    a_row_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && pos.last_col) |=> pos.first_col)
        else $error("column did not wrap after the last column");

    // left cell is empty at the start of a row
    a_left_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && pos.last_col) |=> (left_tap == '0))
        else $error("left neighbor not cleared at row start");

endmodule

`default_nettype wire
